// ===== hw/rtl/bbl_pkg.sv =====
package bbl_pkg;

  // request and response codes
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    RESP_WRITE_DONE = 2'd0,
    RESP_RUN_DONE   = 2'd1,
    RESP_READ_DATA  = 2'd2
  } resp_t;

  // configuration register indexes
  localparam logic [2:0] CFG_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_RADIUS0 = 3'd2;
  localparam logic [2:0] CFG_RADIUS1 = 3'd3;
  localparam logic [2:0] CFG_RADIUS2 = 3'd4;

  localparam int SIZE_W   = 9;
  localparam int RADIUS_W = 6;
  localparam int PIX_W    = 8;
  localparam int CFG_IDX_W = 3;

  // fixed point reciprocal: ceil(2^FRAC / window)
  localparam int FRAC    = 24;
  localparam int RECIP_W = FRAC + 1;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_READ,
    TOP_RUN
  } top_state_t;

  typedef enum logic [3:0] {
    ENG_IDLE,
    ENG_PASS,
    ENG_DIV,
    ENG_LINE,
    ENG_INIT_RD,
    ENG_INIT_ACC,
    ENG_MUL,
    ENG_WR,
    ENG_ADD_RD,
    ENG_ADD_ACC,
    ENG_SUB_RD,
    ENG_SUB_ACC
  } eng_state_t;

endpackage

// ===== hw/rtl/bbl_if.sv =====
interface bbl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic [7:0] pixel_value;

  modport source (output valid, req_type, pixel_x, pixel_y, pixel_value, input ready);
  modport sink (input valid, req_type, pixel_x, pixel_y, pixel_value, output ready);
endinterface

interface bbl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] resp_kind;
  logic [7:0] read_value;

  modport source (output valid, resp_kind, read_value, input ready);
  modport sink (input valid, resp_kind, read_value, output ready);
endinterface

// ===== hw/rtl/bbl_ram.sv =====
module bbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule

// ===== hw/rtl/bbl_recip.sv =====
module bbl_recip #(
  parameter int WW = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [WW-1:0]               win,
  output logic                        done_r,
  output logic [bbl_pkg::RECIP_W-1:0] quot
);

  localparam int NW = bbl_pkg::RECIP_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    num_r, num_nxt;
  logic [WW:0]      rem_r, rem_nxt;
  logic [WW-1:0]    win_r, win_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_nxt;
  logic [WW:0]      rem_s;
  logic             take;

  assign quot = num_r;

  // one quotient bit a cycle, restoring division of 2^FRAC + win - 1 by win
  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    win_nxt  = win_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_s    = {rem_r[WW-1:0], num_r[NW-1]};
    take     = rem_s >= {1'b0, win_r};
    if (start) begin
      num_nxt  = (NW'(1) << bbl_pkg::FRAC) + NW'(win) - NW'(1);
      rem_nxt  = '0;
      win_nxt  = win;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = take ? rem_s - {1'b0, win_r} : rem_s;
      num_nxt = {num_r[NW-2:0], take};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    win_r <= win_nxt;
  end

endmodule

// ===== hw/rtl/bbl_engine.sv =====
module bbl_engine #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 63,
  parameter int NUM_PASSES = 3,
  parameter int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT,
  parameter int CW    = $clog2(MAXD + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [CW-1:0]                  eff_w,
  input  logic [CW-1:0]                  eff_h,
  input  logic [bbl_pkg::RADIUS_W-1:0]   radius [3],
  output logic                           done,
  // host access to the image memory while idle
  input  logic                           host_we,
  input  logic [AW-1:0]                  host_addr,
  input  logic [bbl_pkg::PIX_W-1:0]      host_wdata,
  output logic [bbl_pkg::PIX_W-1:0]      host_rdata
);

  localparam int RW  = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
  localparam int WW  = RW + 1;
  localparam int PW  = $clog2(MAXD + MAX_RADIUS + 2) + 1;
  localparam int SW  = bbl_pkg::PIX_W + $clog2(2 * MAX_RADIUS + 2);
  localparam int MW  = SW + bbl_pkg::RECIP_W;
  localparam int PSW = (NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1;

  bbl_pkg::eng_state_t state_r, state_nxt;

  logic [PSW-1:0]           pass_r, pass_nxt;
  logic                     vert_r, vert_nxt;
  logic [RW-1:0]            r_r, r_nxt;
  logic [CW-1:0]            line_r, line_nxt;
  logic [CW-1:0]            pos_r, pos_nxt;
  logic signed [PW-1:0]     k_r, k_nxt;
  logic [SW-1:0]            sum_r, sum_nxt;
  logic [MW-1:0]            prod_r, prod_nxt;

  logic [RW-1:0]            r_sat;
  logic [bbl_pkg::RADIUS_W-1:0] r_sel;
  logic                     div_start, div_done;
  logic [bbl_pkg::RECIP_W-1:0] recip;

  logic [CW-1:0]            n_len, n_lines;
  logic signed [PW-1:0]     rd_idx;
  logic [CW-1:0]            rd_pos;
  logic [CW-1:0]            addr_pos;
  logic [AW-1:0]            eng_addr;
  logic                     eng_we;
  logic [bbl_pkg::PIX_W-1:0] eng_wdata;
  logic [bbl_pkg::PIX_W-1:0] img_rdata, tmp_rdata, src_rdata;
  logic                     img_we, tmp_we;
  logic [AW-1:0]            img_addr;
  logic                     busy;

  // edge repeat: clamp a signed index into 0 .. n-1
  function automatic logic [CW-1:0] clamp_idx(input logic signed [PW-1:0] v,
                                               input logic [CW-1:0] n);
    logic signed [PW-1:0] ns;
    ns = $signed({{(PW - CW){1'b0}}, n});
    if (v < 0) return '0;
    else if (v >= ns) return n - CW'(1);
    else return v[CW-1:0];
  endfunction

  // radius of the current pass, saturated
  assign r_sel = radius[pass_r];
  assign r_sat = (r_sel > bbl_pkg::RADIUS_W'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(r_sel);

  bbl_recip #(.WW(WW)) u_recip (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .win    ({r_sat, 1'b1}),
    .done_r (div_done),
    .quot   (recip)
  );

  // rows for horizontal, columns for vertical
  assign n_len   = vert_r ? eff_h : eff_w;
  assign n_lines = vert_r ? eff_w : eff_h;

  // memory addressing: line and position map to row and column
  assign rd_pos   = clamp_idx(rd_idx, n_len);
  assign addr_pos = (state_r == bbl_pkg::ENG_WR) ? pos_r : rd_pos;
  always_comb begin
    if (vert_r) eng_addr = AW'(addr_pos) * AW'(MAX_WIDTH) + AW'(line_r);
    else        eng_addr = AW'(line_r) * AW'(MAX_WIDTH) + AW'(addr_pos);
  end

  assign busy      = state_r != bbl_pkg::ENG_IDLE;
  assign eng_we    = state_r == bbl_pkg::ENG_WR;
  assign eng_wdata = prod_r[bbl_pkg::FRAC +: bbl_pkg::PIX_W];
  assign img_we    = busy ? (eng_we && vert_r) : host_we;
  assign img_addr  = busy ? eng_addr : host_addr;
  assign tmp_we    = eng_we && !vert_r;
  assign src_rdata = vert_r ? tmp_rdata : img_rdata;
  assign host_rdata = img_rdata;

  bbl_ram #(.WIDTH(bbl_pkg::PIX_W), .DEPTH(DEPTH), .AW(AW)) u_image (
    .clk     (clk),
    .we      (img_we),
    .addr    (img_addr),
    .wdata   (busy ? eng_wdata : host_wdata),
    .rdata_r (img_rdata)
  );

  bbl_ram #(.WIDTH(bbl_pkg::PIX_W), .DEPTH(DEPTH), .AW(AW)) u_temp (
    .clk     (clk),
    .we      (tmp_we),
    .addr    (eng_addr),
    .wdata   (eng_wdata),
    .rdata_r (tmp_rdata)
  );

  // pass sequencer: running window sum along each line
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    vert_nxt  = vert_r;
    r_nxt     = r_r;
    line_nxt  = line_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    sum_nxt   = sum_r;
    prod_nxt  = prod_r;
    div_start = 1'b0;
    done      = 1'b0;
    rd_idx    = k_r;
    unique case (state_r)
      bbl_pkg::ENG_IDLE: begin
        if (start) begin
          pass_nxt  = '0;
          state_nxt = bbl_pkg::ENG_PASS;
        end
      end
      bbl_pkg::ENG_PASS: begin
        r_nxt     = r_sat;
        vert_nxt  = 1'b0;
        line_nxt  = '0;
        div_start = 1'b1;
        state_nxt = bbl_pkg::ENG_DIV;
      end
      bbl_pkg::ENG_DIV: begin
        if (div_done) state_nxt = bbl_pkg::ENG_LINE;
      end
      bbl_pkg::ENG_LINE: begin
        sum_nxt   = '0;
        pos_nxt   = '0;
        k_nxt     = -$signed({{(PW - RW){1'b0}}, r_r});
        state_nxt = bbl_pkg::ENG_INIT_RD;
      end
      bbl_pkg::ENG_INIT_RD: begin
        rd_idx    = k_r;
        state_nxt = bbl_pkg::ENG_INIT_ACC;
      end
      bbl_pkg::ENG_INIT_ACC: begin
        sum_nxt = sum_r + SW'(src_rdata);
        k_nxt   = k_r + PW'(1);
        if (k_r == $signed({{(PW - RW){1'b0}}, r_r})) state_nxt = bbl_pkg::ENG_MUL;
        else                                           state_nxt = bbl_pkg::ENG_INIT_RD;
      end
      bbl_pkg::ENG_MUL: begin
        prod_nxt  = MW'(sum_r) * MW'(recip);
        state_nxt = bbl_pkg::ENG_WR;
      end
      bbl_pkg::ENG_WR: begin
        pos_nxt = pos_r + CW'(1);
        if (pos_r == n_len - CW'(1)) begin
          line_nxt = line_r + CW'(1);
          if (line_r == n_lines - CW'(1)) begin
            line_nxt = '0;
            if (!vert_r) begin
              vert_nxt  = 1'b1;
              state_nxt = bbl_pkg::ENG_LINE;
            end else if (pass_r == PSW'(NUM_PASSES - 1)) begin
              done      = 1'b1;
              state_nxt = bbl_pkg::ENG_IDLE;
            end else begin
              pass_nxt  = pass_r + PSW'(1);
              state_nxt = bbl_pkg::ENG_PASS;
            end
          end else begin
            state_nxt = bbl_pkg::ENG_LINE;
          end
        end else begin
          state_nxt = bbl_pkg::ENG_ADD_RD;
        end
      end
      bbl_pkg::ENG_ADD_RD: begin
        rd_idx    = $signed({{(PW - CW){1'b0}}, pos_r}) + $signed({{(PW - RW){1'b0}}, r_r});
        state_nxt = bbl_pkg::ENG_ADD_ACC;
      end
      bbl_pkg::ENG_ADD_ACC: begin
        sum_nxt   = sum_r + SW'(src_rdata);
        state_nxt = bbl_pkg::ENG_SUB_RD;
      end
      bbl_pkg::ENG_SUB_RD: begin
        rd_idx    = $signed({{(PW - CW){1'b0}}, pos_r}) - $signed({{(PW - RW){1'b0}}, r_r})
                    - PW'(1);
        state_nxt = bbl_pkg::ENG_SUB_ACC;
      end
      bbl_pkg::ENG_SUB_ACC: begin
        sum_nxt   = sum_r - SW'(src_rdata);
        state_nxt = bbl_pkg::ENG_MUL;
      end
      default: state_nxt = bbl_pkg::ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bbl_pkg::ENG_IDLE;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
    end
    pass_r <= pass_nxt;
    vert_r <= vert_nxt;
    r_r    <= r_nxt;
    line_r <= line_nxt;
    pos_r  <= pos_nxt;
    k_r    <= k_nxt;
    prod_r <= prod_nxt;
  end

endmodule

// ===== hw/rtl/three_pass_box_blur_a8.sv =====
// Three-pass box blur of an 8-bit alpha image held in two on-chip memories
// (image and scratch). Pixel write items can be taken every cycle while each
// response is taken; a read item holds the input in a read state and answers
// once the registered memory read is back. A run item blurs the configured
// width w by height h region with three passes, each a horizontal then a
// vertical box blur with its own radius r, and answers once when done. Each
// line primes the window by reading and accumulating its 2r+1 pixels, then
// scales and writes its first pixel; each further pixel takes an add read and
// accumulate, a subtract read and accumulate, a scale multiply and a write
// back on the single port of the source memory. Each pass first runs its
// reciprocal divider. Configure only while no item is in flight.
module three_pass_box_blur_a8 #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 63,
  parameter int NUM_PASSES = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bbl_in_if.sink                          in_ch,
  bbl_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [bbl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbl_pkg::SIZE_W-1:0]      cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW    = $clog2(MAXD + 1);

  bbl_pkg::top_state_t state_r, state_nxt;

  logic [bbl_pkg::SIZE_W-1:0]   width_r, height_r;
  logic [bbl_pkg::RADIUS_W-1:0] radius_r [3];
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   out_kind_r, out_kind_nxt;
  logic [bbl_pkg::PIX_W-1:0]    out_val_r, out_val_nxt;
  logic [CW-1:0]                eff_w, eff_h;
  logic                         accept, in_store, host_we, eng_start, eng_done;
  logic [AW-1:0]                host_addr;
  logic [bbl_pkg::PIX_W-1:0]    host_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= bbl_pkg::SIZE_W'(256);
      height_r    <= bbl_pkg::SIZE_W'(256);
      radius_r[0] <= '0;
      radius_r[1] <= '0;
      radius_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbl_pkg::CFG_WIDTH:   width_r     <= cfg_wdata;
        bbl_pkg::CFG_HEIGHT:  height_r    <= cfg_wdata;
        bbl_pkg::CFG_RADIUS0: radius_r[0] <= cfg_wdata[bbl_pkg::RADIUS_W-1:0];
        bbl_pkg::CFG_RADIUS1: radius_r[1] <= cfg_wdata[bbl_pkg::RADIUS_W-1:0];
        bbl_pkg::CFG_RADIUS2: radius_r[2] <= cfg_wdata[bbl_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // size in use, zero acts as one, saturate at the store size
  always_comb begin
    if (width_r == '0)              eff_w = CW'(1);
    else if (width_r > MAX_WIDTH)   eff_w = CW'(MAX_WIDTH);
    else                            eff_w = CW'(width_r);
    if (height_r == '0)             eff_h = CW'(1);
    else if (height_r > MAX_HEIGHT) eff_h = CW'(MAX_HEIGHT);
    else                            eff_h = CW'(height_r);
  end

  assign in_store  = (in_ch.pixel_x < MAX_WIDTH) && (in_ch.pixel_y < MAX_HEIGHT);
  assign host_addr = AW'(in_ch.pixel_y) * AW'(MAX_WIDTH) + AW'(in_ch.pixel_x);

  assign in_ch.ready      = (state_r == bbl_pkg::TOP_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept           = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.resp_kind = out_kind_r;
  assign out_ch.read_value = out_val_r;

  bbl_engine #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS),
    .NUM_PASSES (NUM_PASSES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (eng_start),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .radius     (radius_r),
    .done       (eng_done),
    .host_we    (host_we),
    .host_addr  (host_addr),
    .host_wdata (in_ch.pixel_value),
    .host_rdata (host_rdata)
  );

  // request decode and response register
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_val_nxt   = out_val_r;
    host_we       = 1'b0;
    eng_start     = 1'b0;
    unique case (state_r)
      bbl_pkg::TOP_IDLE: begin
        if (accept) begin
          unique case (bbl_pkg::req_t'(in_ch.req_type))
            bbl_pkg::REQ_WRITE: begin
              host_we       = in_store;
              out_valid_nxt = 1'b1;
              out_kind_nxt  = bbl_pkg::RESP_WRITE_DONE;
              out_val_nxt   = '0;
            end
            bbl_pkg::REQ_RUN: begin
              eng_start = 1'b1;
              state_nxt = bbl_pkg::TOP_RUN;
            end
            bbl_pkg::REQ_READ: begin
              if (in_store) begin
                state_nxt = bbl_pkg::TOP_READ;
              end else begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = bbl_pkg::RESP_READ_DATA;
                out_val_nxt   = '0;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = bbl_pkg::RESP_WRITE_DONE;
              out_val_nxt   = '0;
            end
          endcase
        end
      end
      bbl_pkg::TOP_READ: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = bbl_pkg::RESP_READ_DATA;
        out_val_nxt   = host_rdata;
        state_nxt     = bbl_pkg::TOP_IDLE;
      end
      bbl_pkg::TOP_RUN: begin
        if (eng_done) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = bbl_pkg::RESP_RUN_DONE;
          out_val_nxt   = '0;
          state_nxt     = bbl_pkg::TOP_IDLE;
        end
      end
      default: state_nxt = bbl_pkg::TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbl_pkg::TOP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r <= out_kind_nxt;
    out_val_r  <= out_val_nxt;
  end

endmodule
